// File: rtl/core/arde_pkg.sv
// Shared types, flag codes and segment codes for the access record delta encoder.
package arde_pkg;

    // Queue depth between the classifier and the byte serializer
    localparam int QUEUE_DEPTH_DEF = 2;

    // Flag byte bits
    localparam logic [7:0] FLG_PC   = 8'h01;
    localparam logic [7:0] FLG_ADDR = 8'h02;
    localparam logic [7:0] FLG_TIME = 8'h04;
    localparam logic [7:0] FLG_TID  = 8'h10;
    localparam logic [7:0] FLG_LEN  = 8'h20;
    localparam logic [7:0] FLG_TYPE = 8'h40;

    // One input record
    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] address;
        logic [63:0] timestamp;
        logic [15:0] thread_id;
        logic [15:0] access_length;
        logic [7:0]  access_type;
    } in_t;

    // One output byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    // Classified record passed from the front to the back
    typedef struct packed {
        logic [7:0]  flags;
        logic [63:0] pc;
        logic [63:0] address;
        logic [63:0] timestamp;
        logic [7:0]  pc_delta;
        logic [7:0]  addr_delta;
        logic [7:0]  time_delta;
        logic [15:0] thread_id;
        logic [15:0] access_length;
        logic [7:0]  access_type;
        logic [4:0]  total;
    } rec_t;

    // Fields of the output stream, in emission order
    typedef enum logic [2:0] {
        SEG_FLAG,
        SEG_PC,
        SEG_ADDR,
        SEG_TIME,
        SEG_TID,
        SEG_LEN,
        SEG_TYPE
    } seg_t;

endpackage

// File: rtl/core/arde_front.sv
// Front stage: compares each record with the reference values and classifies its fields.
module arde_front (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  arde_pkg::in_t s_data,
    output logic         push_valid,
    input  logic         push_ready,
    output arde_pkg::rec_t push_data
);
    import arde_pkg::*;

    logic [63:0] prev_pc_reg, prev_pc_next;
    logic [63:0] prev_addr_reg, prev_addr_next;
    logic [63:0] prev_time_reg, prev_time_next;
    logic [15:0] prev_tid_reg, prev_tid_next;
    logic [15:0] prev_len_reg, prev_len_next;
    logic [7:0]  prev_type_reg, prev_type_next;

    logic [63:0] pc_diff, addr_diff, time_diff;
    logic        pc_small, addr_small, time_small;
    logic        tid_same, len_same, type_same;
    logic        accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid & push_ready;

    // Wrapping differences against the references
    assign pc_diff   = s_data.pc - prev_pc_reg;
    assign addr_diff = s_data.address - prev_addr_reg;
    assign time_diff = s_data.timestamp - prev_time_reg;

    // A difference fits one signed byte when its top 57 bits agree
    assign pc_small   = (&pc_diff[63:7]) | ~(|pc_diff[63:7]);
    assign addr_small = (&addr_diff[63:7]) | ~(|addr_diff[63:7]);
    assign time_small = (&time_diff[63:7]) | ~(|time_diff[63:7]);

    assign tid_same  = (s_data.thread_id == prev_tid_reg);
    assign len_same  = (s_data.access_length == prev_len_reg);
    assign type_same = (s_data.access_type == prev_type_reg);

    // Build the classified record and its byte count
    always_comb begin
        push_data.flags = (pc_small ? FLG_PC : 8'h00)
                        | (addr_small ? FLG_ADDR : 8'h00)
                        | (time_small ? FLG_TIME : 8'h00)
                        | (tid_same ? FLG_TID : 8'h00)
                        | (len_same ? FLG_LEN : 8'h00)
                        | (type_same ? FLG_TYPE : 8'h00);
        push_data.pc            = s_data.pc;
        push_data.address       = s_data.address;
        push_data.timestamp     = s_data.timestamp;
        push_data.pc_delta      = pc_diff[7:0];
        push_data.addr_delta    = addr_diff[7:0];
        push_data.time_delta    = time_diff[7:0];
        push_data.thread_id     = s_data.thread_id;
        push_data.access_length = s_data.access_length;
        push_data.access_type   = s_data.access_type;
        push_data.total = 5'd1
                        + (pc_small ? 5'd1 : 5'd8)
                        + (addr_small ? 5'd1 : 5'd8)
                        + (time_small ? 5'd1 : 5'd8)
                        + (tid_same ? 5'd0 : 5'd2)
                        + (len_same ? 5'd0 : 5'd2)
                        + (type_same ? 5'd0 : 5'd1);
    end

    // Replace references on every accepted item
    always_comb begin
        prev_pc_next   = prev_pc_reg;
        prev_addr_next = prev_addr_reg;
        prev_time_next = prev_time_reg;
        prev_tid_next  = prev_tid_reg;
        prev_len_next  = prev_len_reg;
        prev_type_next = prev_type_reg;
        if (accept) begin
            prev_pc_next   = s_data.pc;
            prev_addr_next = s_data.address;
            prev_time_next = s_data.timestamp;
            prev_tid_next  = s_data.thread_id;
            prev_len_next  = s_data.access_length;
            prev_type_next = s_data.access_type;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pc_reg   <= '0;
            prev_addr_reg <= '0;
            prev_time_reg <= '0;
            prev_tid_reg  <= '0;
            prev_len_reg  <= '0;
            prev_type_reg <= '0;
        end else begin
            prev_pc_reg   <= prev_pc_next;
            prev_addr_reg <= prev_addr_next;
            prev_time_reg <= prev_time_next;
            prev_tid_reg  <= prev_tid_next;
            prev_len_reg  <= prev_len_next;
            prev_type_reg <= prev_type_next;
        end
    end

endmodule

// File: rtl/core/arde_queue.sv
// Short queue of classified records between the front and the back.
module arde_queue #(
    parameter int DEPTH = arde_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  arde_pkg::rec_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output arde_pkg::rec_t pop_data
);
    import arde_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Advance pointers with wrap and track occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/arde_back.sv
// Back stage: serializes one classified record into bytes behind an output register.
module arde_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  arde_pkg::rec_t pop_data,
    output logic           m_valid,
    input  logic           m_ready,
    output arde_pkg::out_t m_data
);
    import arde_pkg::*;

    rec_t       rec_reg, rec_next;
    logic       busy_reg, busy_next;
    seg_t       seg_reg, seg_next;
    logic [2:0] idx_reg, idx_next;
    logic [4:0] rem_reg, rem_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_data_reg, m_data_next;

    logic       advance;
    logic       final_byte;
    logic       load;
    logic       seg_done;
    seg_t       seg_after;
    logic [7:0] cur_byte;

    assign advance    = busy_reg & (~m_valid_reg | m_ready);
    assign final_byte = (rem_reg == 5'd1);
    assign pop_ready  = ~busy_reg | (advance & final_byte);
    assign load       = pop_valid & pop_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Select the current byte and detect the end of its field
    always_comb begin
        cur_byte = 8'h00;
        seg_done = 1'b1;
        unique case (seg_reg)
            SEG_FLAG: begin
                cur_byte = rec_reg.flags;
            end
            SEG_PC: begin
                cur_byte = (rec_reg.flags & FLG_PC) != 8'h00 ? rec_reg.pc_delta
                         : rec_reg.pc[{idx_reg, 3'b000} +: 8];
                seg_done = (rec_reg.flags & FLG_PC) != 8'h00 || idx_reg == 3'd7;
            end
            SEG_ADDR: begin
                cur_byte = (rec_reg.flags & FLG_ADDR) != 8'h00 ? rec_reg.addr_delta
                         : rec_reg.address[{idx_reg, 3'b000} +: 8];
                seg_done = (rec_reg.flags & FLG_ADDR) != 8'h00 || idx_reg == 3'd7;
            end
            SEG_TIME: begin
                cur_byte = (rec_reg.flags & FLG_TIME) != 8'h00 ? rec_reg.time_delta
                         : rec_reg.timestamp[{idx_reg, 3'b000} +: 8];
                seg_done = (rec_reg.flags & FLG_TIME) != 8'h00 || idx_reg == 3'd7;
            end
            SEG_TID: begin
                cur_byte = idx_reg[0] ? rec_reg.thread_id[15:8] : rec_reg.thread_id[7:0];
                seg_done = idx_reg[0];
            end
            SEG_LEN: begin
                cur_byte = idx_reg[0] ? rec_reg.access_length[15:8]
                         : rec_reg.access_length[7:0];
                seg_done = idx_reg[0];
            end
            SEG_TYPE: begin
                cur_byte = rec_reg.access_type;
            end
            default: begin
                cur_byte = 8'h00;
            end
        endcase
    end

    // Pick the next field that is present in the stream
    always_comb begin
        seg_after = SEG_TYPE;
        unique case (seg_reg)
            SEG_FLAG: seg_after = SEG_PC;
            SEG_PC:   seg_after = SEG_ADDR;
            SEG_ADDR: seg_after = SEG_TIME;
            SEG_TIME: begin
                if ((rec_reg.flags & FLG_TID) == 8'h00) begin
                    seg_after = SEG_TID;
                end else if ((rec_reg.flags & FLG_LEN) == 8'h00) begin
                    seg_after = SEG_LEN;
                end else begin
                    seg_after = SEG_TYPE;
                end
            end
            SEG_TID: begin
                seg_after = ((rec_reg.flags & FLG_LEN) == 8'h00) ? SEG_LEN : SEG_TYPE;
            end
            SEG_LEN:  seg_after = SEG_TYPE;
            SEG_TYPE: seg_after = SEG_TYPE;
            default:  seg_after = SEG_TYPE;
        endcase
    end

    // Sequencer next state: load a record, step through its bytes
    always_comb begin
        rec_next  = rec_reg;
        busy_next = busy_reg;
        seg_next  = seg_reg;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        if (load) begin
            rec_next  = pop_data;
            busy_next = 1'b1;
            seg_next  = SEG_FLAG;
            idx_next  = '0;
            rem_next  = pop_data.total;
        end else if (advance) begin
            if (final_byte) begin
                busy_next = 1'b0;
            end else begin
                rem_next = rem_reg - 5'd1;
                if (seg_done) begin
                    seg_next = seg_after;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    // Output register: fill on advance, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = cur_byte;
            m_data_next.last     = final_byte;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            seg_reg     <= SEG_FLAG;
            idx_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            seg_reg     <= seg_next;
            idx_reg     <= idx_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rec_reg    <= rec_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: rtl/core/access_record_delta_encoder.sv
// Top level of the access record delta encoder: classifier, record queue and byte serializer.
// Each accepted record comes out as 4 to 30 bytes, a flag byte first, then pc, address and
// timestamp as one delta byte or eight little-endian bytes each, then thread id, length and
// type unless unchanged; last marks the final byte. The output delivers one byte per cycle
// while m_ready is high; the serializer loads the next queued record as it emits the final
// byte of the current one. The front classifies a record combinationally and takes a new
// one each cycle while the QUEUE_DEPTH-entry queue has room, so short bursts of records are
// absorbed while the serializer works on earlier ones.
module access_record_delta_encoder #(
    parameter int QUEUE_DEPTH = arde_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  arde_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output arde_pkg::out_t m_data
);
    import arde_pkg::*;

    logic push_valid, push_ready;
    rec_t push_data;
    logic pop_valid, pop_ready;
    rec_t pop_data;

    // Classify records against the reference values
    arde_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the front from the serializer
    arde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Emit the bytes of each record
    arde_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
